// File: sv/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg: shared types, constants and helpers of the Euler step block.
// Holds the fixed-point limits, register codes, sequencer states and the
// operand bundle that is handed to the shared multiplier.
// ----------------------------------------------------------------------------
package esd_pkg;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;

   localparam logic [31:0] HALF_RHO_Q16   = 32'd40141;
   localparam logic [63:0] FAST_SQ_THRESH = 64'd1073741824;
   localparam logic [63:0] SLOW_SQ_THRESH = 64'd429497;

   localparam logic signed [31:0] GRAVITY_RESET  = -32'sd642253;
   localparam logic signed [31:0] DRAG_RESET     = 32'sd6554;
   localparam logic [30:0]        INV_MASS_RESET = 31'd3277;

   localparam logic CMD_FORCE = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [1:0] CSR_GRAVITY  = 2'd0;
   localparam logic [1:0] CSR_DRAG     = 2'd1;
   localparam logic [1:0] CSR_INV_MASS = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPEED,
      ST_DRAG_SEL,
      ST_DSQ,
      ST_DRHO,
      ST_DCOEF,
      ST_ACC,
      ST_GRAV,
      ST_VEL,
      ST_DADD,
      ST_POS,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic        neg;
   } mul_op_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? (~v + 32'd1) : v;
      return r;
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] sum;
      sum = {a[31], a} + {b[31], b};
      if (sum[32] != sum[31]) begin
         return sum[32] ? Q_MIN : Q_MAX;
      end
      return sum[31:0];
   endfunction

endpackage

// File: sv/esd_mul_unit.sv
// ----------------------------------------------------------------------------
// esd_mul_unit: shared sign-magnitude multiplier.
// Registers the 64-bit product of two magnitudes, then gives the raw product
// and the Q16.16 result shifted, signed and saturated to 32 bits.
// ----------------------------------------------------------------------------
module esd_mul_unit (
   input  logic                clock,
   input  esd_pkg::mul_op_type op,
   output logic [63:0]         prod,
   output logic signed [31:0]  qsat
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;
   logic        neg_ff;
   logic        neg_in;
   logic [47:0] mag_q;

   assign prod_in = 64'(op.mag_a) * 64'(op.mag_b);
   assign neg_in  = op.neg;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
   end

   assign prod  = prod_ff;
   assign mag_q = prod_ff[63:16];

   always_comb begin
      if (neg_ff) begin
         if (mag_q > 48'h0000_8000_0000) begin
            qsat = esd_pkg::Q_MIN;
         end else begin
            qsat = ~mag_q[31:0] + 32'd1;
         end
      end else begin
         if (mag_q > 48'h0000_7FFF_FFFF) begin
            qsat = esd_pkg::Q_MAX;
         end else begin
            qsat = mag_q[31:0];
         end
      end
   end

endmodule

// File: sv/euler_step_with_drag_top.sv
// ----------------------------------------------------------------------------
// euler_step_with_drag_top: semi-implicit Euler step of one body with drag.
// A force beat is absorbed and yields no result beat.
// A step beat yields one result beat (no drag, linear drag, quadratic drag);
// all products go through the one shared multiplier, and the sequencer waits
// for each product before it issues the next. The next beat can be accepted
// once the result beat is in the output register, and a result beat still held at the output stalls the block.
// Reset clears position, velocity and force and loads the default registers.
// ----------------------------------------------------------------------------
module euler_step_with_drag_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // force_x, force_y, force_z, time_delta, zero fill
   input  logic [119:0] req_tdata,
   // cmd
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   output logic [191:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   esd_pkg::state_type state_ff, state_in;
   logic               phase_ff, phase_in;
   logic [1:0]         axis_ff, axis_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [191:0]       rsp_data_ff, rsp_data_in;

   logic signed [31:0] grav_ff, grav_in;
   logic signed [31:0] dc_ff, dc_in;
   logic [30:0]        inv_ff, inv_in;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] vel_in [3];
   logic signed [31:0] force_ff [3];
   logic signed [31:0] force_in [3];

   logic [63:0]        s_ff, s_in;
   logic [31:0]        tmp_ff, tmp_in;
   logic               big_ff, big_in;
   logic signed [31:0] drag_ff, drag_in;
   logic signed [31:0] acc_ff, acc_in;
   logic [19:0]        dt_ff, dt_in;

   esd_pkg::mul_op_type mul_op;
   logic [63:0]         prod;
   logic signed [31:0]  qsat;

   logic               req_fire;
   logic               rsp_free;
   logic signed [31:0] vel_cur;
   logic signed [31:0] pos_cur;
   logic signed [31:0] force_cur;
   logic [31:0]        w_mag;
   logic               w_neg;
   logic               fast;
   logic               slow;

   esd_mul_unit u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod),
      .qsat  (qsat)
   );

   assign req_tready = (state_ff == esd_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign vel_cur   = vel_ff[axis_ff];
   assign pos_cur   = pos_ff[axis_ff];
   assign force_cur = force_ff[axis_ff];
   assign w_mag     = (vel_cur == esd_pkg::Q_MIN) ? esd_pkg::Q_MAX : esd_pkg::mag32(vel_cur);
   assign w_neg     = !vel_cur[31] && (vel_cur != 32'sd0);
   assign fast      = s_ff > esd_pkg::FAST_SQ_THRESH;
   assign slow      = s_ff > esd_pkg::SLOW_SQ_THRESH;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         esd_pkg::ST_IDLE: begin
            if (req_fire && req_tuser == esd_pkg::CMD_STEP) begin
               state_in = esd_pkg::ST_SPEED;
            end
         end
         esd_pkg::ST_SPEED: begin
            if (phase_ff && axis_ff == 2'd2) begin
               state_in = esd_pkg::ST_DRAG_SEL;
            end
         end
         esd_pkg::ST_DRAG_SEL: begin
            if (fast) begin
               state_in = esd_pkg::ST_DSQ;
            end else if (slow) begin
               state_in = esd_pkg::ST_DCOEF;
            end else begin
               state_in = esd_pkg::ST_ACC;
            end
         end
         esd_pkg::ST_DSQ: begin
            if (phase_ff) state_in = esd_pkg::ST_DRHO;
         end
         esd_pkg::ST_DRHO: begin
            if (phase_ff) state_in = esd_pkg::ST_DCOEF;
         end
         esd_pkg::ST_DCOEF: begin
            if (phase_ff) state_in = esd_pkg::ST_ACC;
         end
         esd_pkg::ST_ACC: begin
            if (phase_ff) begin
               state_in = (axis_ff == 2'd1) ? esd_pkg::ST_GRAV : esd_pkg::ST_VEL;
            end
         end
         esd_pkg::ST_GRAV: state_in = esd_pkg::ST_VEL;
         esd_pkg::ST_VEL: begin
            if (phase_ff) state_in = esd_pkg::ST_DADD;
         end
         esd_pkg::ST_DADD: state_in = esd_pkg::ST_POS;
         esd_pkg::ST_POS: begin
            if (phase_ff) begin
               state_in = (axis_ff == 2'd2) ? esd_pkg::ST_FINISH : esd_pkg::ST_DRAG_SEL;
            end
         end
         esd_pkg::ST_FINISH: begin
            if (rsp_free) state_in = esd_pkg::ST_IDLE;
         end
         default: state_in = esd_pkg::ST_IDLE;
      endcase
   end

   // Datapath, multiplier operands and write-back.
   always_comb begin
      phase_in     = 1'b0;
      axis_in      = axis_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      grav_in      = grav_ff;
      dc_in        = dc_ff;
      inv_in       = inv_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      force_in     = force_ff;
      s_in         = s_ff;
      tmp_in       = tmp_ff;
      big_in       = big_ff;
      drag_in      = drag_ff;
      acc_in       = acc_ff;
      dt_in        = dt_ff;
      mul_op       = '0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            esd_pkg::CSR_GRAVITY:  grav_in = csr_data;
            esd_pkg::CSR_DRAG:     dc_in   = csr_data;
            esd_pkg::CSR_INV_MASS: inv_in  = csr_data[30:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         esd_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == esd_pkg::CMD_STEP) begin
                  dt_in   = req_tdata[115:96];
                  s_in    = 64'd0;
                  axis_in = 2'd0;
               end else begin
                  force_in[0] = esd_pkg::sat_add(force_ff[0], req_tdata[31:0]);
                  force_in[1] = esd_pkg::sat_add(force_ff[1], req_tdata[63:32]);
                  force_in[2] = esd_pkg::sat_add(force_ff[2], req_tdata[95:64]);
               end
            end
         end
         esd_pkg::ST_SPEED: begin
            phase_in     = !phase_ff;
            mul_op.mag_a = esd_pkg::mag32(vel_cur);
            mul_op.mag_b = esd_pkg::mag32(vel_cur);
            if (phase_ff) begin
               s_in    = s_ff + prod;
               axis_in = (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
            end
         end
         esd_pkg::ST_DRAG_SEL: begin
            drag_in = 32'sd0;
         end
         esd_pkg::ST_DSQ: begin
            phase_in     = !phase_ff;
            mul_op.mag_a = w_mag;
            mul_op.mag_b = w_mag;
            if (phase_ff) begin
               big_in = |prod[63:48];
               tmp_in = prod[47:16];
            end
         end
         esd_pkg::ST_DRHO: begin
            phase_in     = !phase_ff;
            mul_op.mag_a = tmp_ff;
            mul_op.mag_b = esd_pkg::HALF_RHO_Q16;
            if (phase_ff) begin
               tmp_in = (big_ff || |prod[63:47]) ? esd_pkg::Q_MAX : prod[47:16];
            end
         end
         esd_pkg::ST_DCOEF: begin
            phase_in     = !phase_ff;
            mul_op.mag_a = fast ? tmp_ff : w_mag;
            mul_op.mag_b = esd_pkg::mag32(dc_ff);
            mul_op.neg   = w_neg ^ dc_ff[31];
            if (phase_ff) drag_in = qsat;
         end
         esd_pkg::ST_ACC: begin
            phase_in     = !phase_ff;
            mul_op.mag_a = esd_pkg::mag32(force_cur);
            mul_op.mag_b = {1'b0, inv_ff};
            mul_op.neg   = force_cur[31];
            if (phase_ff) acc_in = qsat;
         end
         esd_pkg::ST_GRAV: begin
            acc_in = esd_pkg::sat_add(acc_ff, grav_ff);
         end
         esd_pkg::ST_VEL: begin
            phase_in     = !phase_ff;
            mul_op.mag_a = esd_pkg::mag32(acc_ff);
            mul_op.mag_b = {12'd0, dt_ff};
            mul_op.neg   = acc_ff[31];
            if (phase_ff) vel_in[axis_ff] = esd_pkg::sat_add(vel_cur, qsat);
         end
         esd_pkg::ST_DADD: begin
            vel_in[axis_ff] = esd_pkg::sat_add(vel_cur, drag_ff);
         end
         esd_pkg::ST_POS: begin
            phase_in     = !phase_ff;
            mul_op.mag_a = esd_pkg::mag32(vel_cur);
            mul_op.mag_b = {12'd0, dt_ff};
            mul_op.neg   = vel_cur[31];
            if (phase_ff) begin
               pos_in[axis_ff]   = esd_pkg::sat_add(pos_cur, qsat);
               force_in[axis_ff] = 32'sd0;
               axis_in           = (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
            end
         end
         esd_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {vel_ff[2], vel_ff[1], vel_ff[0],
                               pos_ff[2], pos_ff[1], pos_ff[0]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esd_pkg::ST_IDLE;
         phase_ff     <= 1'b0;
         axis_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
         grav_ff      <= esd_pkg::GRAVITY_RESET;
         dc_ff        <= esd_pkg::DRAG_RESET;
         inv_ff       <= esd_pkg::INV_MASS_RESET;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]   <= 32'sd0;
            vel_ff[i]   <= 32'sd0;
            force_ff[i] <= 32'sd0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         grav_ff      <= grav_in;
         dc_ff        <= dc_in;
         inv_ff       <= inv_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         force_ff     <= force_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      s_ff        <= s_in;
      tmp_ff      <= tmp_in;
      big_ff      <= big_in;
      drag_ff     <= drag_in;
      acc_ff      <= acc_in;
      dt_ff       <= dt_in;
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Euler step with drag block.
// A directed table opens the run, then eight register settings each get a
// stretch of random force and step sequences. Every step beat is predicted
// by a fixed-point body model kept in the bench, and every result beat is
// compared field by field with the oldest expected beat. Both stream sides
// idle at random, and the sender sometimes waits until all results are in.
// ----------------------------------------------------------------------------
module tb;

   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          SETTLE_CYCLES = 80;
   localparam int          PHASE_COUNT   = 8;
   localparam int          PHASE_BEATS   = 210;
   localparam logic [1:0]  CSR_UNUSED    = 2'd3;
   localparam longint      FIX_MAX       = 64'sd2147483647;
   localparam longint      FIX_MIN       = -64'sd2147483648;
   localparam logic [63:0] HALF_RHO      = 64'd40141;
   localparam logic [63:0] FAST_SPEED_SQ = 64'd1073741824;
   localparam logic [63:0] SLOW_SPEED_SQ = 64'd429497;
   localparam logic [31:0] WORD_MAX      = 32'h7FFFFFFF;
   localparam logic [31:0] WORD_MIN      = 32'h80000000;
   localparam logic [31:0] FALL_ONE_SEC  = -32'sd642253;

   typedef struct packed {
      logic         cmd;
      logic [31:0]  fx;
      logic [31:0]  fy;
      logic [31:0]  fz;
      logic [19:0]  dt;
      logic         typed;
      logic [191:0] beat;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [119:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [191:0] rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_data;

   longint       gravity_q  = -642253;
   longint       drag_q     = 6554;
   longint       inv_mass_q = 3277;
   longint       body_pos [3];
   longint       body_vel [3];
   longint       force_acc [3];

   logic [191:0] pending_beats [$];
   int           error_count = 0;
   int           stall_left  = 0;
   bit           calm        = 1'b0;
   string        field_name [6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

   stim_row_type stim_table [17] = '{
      '{esd_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'd0, 1'b1, 192'd0},
      '{esd_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'h10000, 1'b1,
        {32'd0, FALL_ONE_SEC, 32'd0, 32'd0, FALL_ONE_SEC, 32'd0}},
      '{esd_pkg::CMD_FORCE, WORD_MAX, WORD_MAX, WORD_MAX, 20'hFFFFF, 1'b0, 192'd0},
      '{esd_pkg::CMD_FORCE, WORD_MAX, WORD_MAX, WORD_MAX, 20'h00000, 1'b0, 192'd0},
      '{esd_pkg::CMD_STEP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 20'hFFFFF, 1'b0,
        192'd0},
      '{esd_pkg::CMD_FORCE, WORD_MIN, WORD_MIN, WORD_MIN, 20'hFFFFF, 1'b0, 192'd0},
      '{esd_pkg::CMD_FORCE, WORD_MIN, WORD_MIN, WORD_MIN, 20'h00000, 1'b0, 192'd0},
      '{esd_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'hFFFFF, 1'b0, 192'd0},
      '{esd_pkg::CMD_STEP, WORD_MIN, WORD_MAX, 32'd0, 20'hFFFFF, 1'b0, 192'd0},
      '{esd_pkg::CMD_FORCE, 32'd1, 32'hFFFFFFFF, 32'd0, 20'h55555, 1'b0, 192'd0},
      '{esd_pkg::CMD_STEP, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 20'd1, 1'b0,
        192'd0},
      '{esd_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'd0, 1'b0, 192'd0},
      '{esd_pkg::CMD_FORCE, 32'h00010000, WORD_MIN, WORD_MAX, 20'hAAAAA, 1'b0, 192'd0},
      '{esd_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'h0AAAA, 1'b0, 192'd0},
      '{esd_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'h10000, 1'b0, 192'd0},
      '{esd_pkg::CMD_FORCE, 32'hFFFF0000, 32'h00008000, 32'h12345678, 20'd0, 1'b0, 192'd0},
      '{esd_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'h08000, 1'b0, 192'd0}
   };

   euler_step_with_drag_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_q(input longint v);
      if (v > FIX_MAX) return FIX_MAX;
      if (v < FIX_MIN) return FIX_MIN;
      return v;
   endfunction

   function automatic logic [63:0] mag_q(input longint v);
      logic [63:0] r;
      r = (v < 0) ? -v : v;
      return r;
   endfunction

   function automatic longint mul_q(input longint a, input longint b);
      logic [63:0] p;
      p = (mag_q(a) * mag_q(b)) >> 16;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic logic [191:0] integrate_step(input logic [19:0] dt_raw);
      longint       dt;
      longint       wind;
      longint       drag [3];
      longint       acc [3];
      logic [63:0]  speed_sq;
      logic [63:0]  m;
      logic [191:0] beat;
      dt = {44'd0, dt_raw};
      speed_sq = 64'd0;
      for (int i = 0; i < 3; i++) begin
         m = mag_q(body_vel[i]);
         speed_sq = speed_sq + m * m;
      end
      for (int i = 0; i < 3; i++) begin
         wind = clamp_q(-body_vel[i]);
         if (speed_sq > FAST_SPEED_SQ) begin
            m = mag_q(wind);
            m = (m * m) >> 16;
            m = (m * HALF_RHO) >> 16;
            if (m > 64'd2147483647) m = 64'd2147483647;
            drag[i] = clamp_q(mul_q((wind < 0) ? -longint'(m) : longint'(m), drag_q));
         end else if (speed_sq > SLOW_SPEED_SQ) begin
            drag[i] = clamp_q(mul_q(wind, drag_q));
         end else begin
            drag[i] = 0;
         end
      end
      for (int i = 0; i < 3; i++) acc[i] = clamp_q(mul_q(force_acc[i], inv_mass_q));
      acc[1] = clamp_q(acc[1] + gravity_q);
      for (int i = 0; i < 3; i++) begin
         body_vel[i] = clamp_q(body_vel[i] + clamp_q(mul_q(acc[i], dt)));
         body_vel[i] = clamp_q(body_vel[i] + drag[i]);
         body_pos[i] = clamp_q(body_pos[i] + clamp_q(mul_q(body_vel[i], dt)));
         force_acc[i] = 0;
         beat[32 * i +: 32] = body_pos[i][31:0];
         beat[96 + 32 * i +: 32] = body_vel[i][31:0];
      end
      return beat;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_force(input bit gentle);
      int          r;
      logic [31:0] v;
      r = $urandom_range(0, 9);
      if (gentle) begin
         v = $urandom_range(0, 32767);
      end else if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return 32'd0;
            default: return 32'hFFFFFFFF;
         endcase
      end else if (r < 4) begin
         return $urandom;
      end else begin
         v = $urandom_range(0, 1 << 20);
      end
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic logic [19:0] pick_dt(input bit gentle);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 20'd0;
      if (gentle) return 20'($urandom_range(1, 65536));
      if (r == 1) return 20'hFFFFF;
      if (r == 2) return 20'($urandom);
      return 20'($urandom_range(1, 16384));
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic send_beat(input logic cmd, input logic [31:0] fx, input logic [31:0] fy,
                            input logic [31:0] fz, input logic [19:0] dt,
                            input logic typed, input logic [191:0] typed_beat);
      int           idle;
      logic [31:0]  f [3];
      logic [191:0] predicted;
      idle = calm ? 0 : idle_len();
      repeat (idle) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {4'd0, dt, fz, fy, fx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd == esd_pkg::CMD_STEP) begin
         predicted = integrate_step(dt);
         pending_beats.push_back(typed ? typed_beat : predicted);
      end else begin
         f = '{fx, fy, fz};
         for (int i = 0; i < 3; i++) force_acc[i] = clamp_q(force_acc[i] + longint'($signed(f[i])));
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         esd_pkg::CSR_GRAVITY:  gravity_q  = longint'($signed(value));
         esd_pkg::CSR_DRAG:     drag_q     = longint'($signed(value));
         esd_pkg::CSR_INV_MASS: inv_mass_q = {33'd0, value[30:0]};
         default: ;
      endcase
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready = 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if (!calm) stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      logic [191:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing pending", rsp_tdata));
         end else begin
            want = pending_beats.pop_front();
            for (int f = 0; f < 6; f++) begin
               if (rsp_tdata[32 * f +: 32] !== want[32 * f +: 32])
                  report_mismatch($sformatf("%s got %h expected %h", field_name[f],
                                            rsp_tdata[32 * f +: 32], want[32 * f +: 32]));
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL euler_step_with_drag_top");
      $finish;
   end

   initial begin
      stim_row_type row;
      int           sent;
      int           n_force;
      bit           gentle;
      logic [31:0]  g;
      logic [31:0]  d;
      logic [31:0]  m;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = esd_pkg::CMD_FORCE;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = esd_pkg::CSR_GRAVITY;
      csr_data   = '0;
      for (int i = 0; i < 3; i++) begin
         body_pos[i]  = 0;
         body_vel[i]  = 0;
         force_acc[i] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < 17; r++) begin
         row = stim_table[r];
         send_beat(row.cmd, row.fx, row.fy, row.fz, row.dt, row.typed, row.beat);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         gentle = 1'b0;
         case (p)
            0: begin g = -32'sd642253; d = 32'd6554; m = 32'd3277; end
            1: begin g = WORD_MIN; d = WORD_MAX; m = WORD_MAX; end
            2: begin g = WORD_MAX; d = WORD_MIN; m = 32'd0; end
            3: begin
               g = 32'd0;
               d = $urandom_range(16384, 65536);
               m = 32'd65536;
               gentle = 1'b1;
            end
            4: begin g = 32'd0; d = 32'd0; m = 32'hFFFFFFFF; end
            6: begin
               g = $urandom_range(0, 131072) - 65536;
               d = $urandom_range(0, 65536);
               m = $urandom_range(0, 131072);
               gentle = 1'b1;
            end
            default: begin g = $urandom; d = $urandom; m = $urandom; end
         endcase
         write_reg(esd_pkg::CSR_GRAVITY, g);
         write_reg(esd_pkg::CSR_DRAG, d);
         write_reg(esd_pkg::CSR_INV_MASS, m);
         write_reg(CSR_UNUSED, $urandom);
         @(negedge clock);
         csr_valid = 1'b0;

         calm = ($urandom_range(0, 2) == 0);
         sent = 0;
         while (sent < PHASE_BEATS) begin
            if ($urandom_range(0, 19) == 0) calm = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 39) == 0) wait_idle();
            n_force = $urandom_range(0, 3);
            repeat (n_force)
               send_beat(esd_pkg::CMD_FORCE, pick_force(gentle), pick_force(gentle),
                         pick_force(gentle), 20'($urandom), 1'b0, 192'd0);
            send_beat(esd_pkg::CMD_STEP, $urandom, $urandom, $urandom, pick_dt(gentle),
                      1'b0, 192'd0);
            sent += n_force + 1;
         end
      end

      wait_idle();
      if (error_count == 0 && pending_beats.size() == 0) begin
         $display("PASS euler_step_with_drag_top");
      end else begin
         $display("FAIL euler_step_with_drag_top");
      end
      $finish;
   end

endmodule
